// File: rtl/lsle_pkg.sv
// Shared types, constants and tables for the laser scan landmark extractor.
// No dependencies; every other file in rtl/ imports this package.
`timescale 1ns / 1ps

package lsle_pkg;

    localparam int MAX_RAYS     = 1024;
    localparam int CLUSTER_GAP  = 102;
    localparam int MIN_RANGE    = 102;
    localparam int MIN_POINTS   = 2;
    localparam int CORDIC_STEPS = 16;

    localparam int RAY_W = $clog2(MAX_RAYS);
    localparam int CNT_W = $clog2(MAX_RAYS + 1);
    localparam int CW    = 36;   // cordic x/y width
    localparam int ZW    = 34;   // cordic angle width, pi = 2^31
    localparam int SUM_W = 34;
    localparam int RAD_W = 44;

    localparam logic [16:0] CORDIC_GAIN = 17'd39797;
    localparam logic signed [CW-1:0] CRD_HALF = CW'(32768);
    localparam logic signed [ZW-1:0] Z_HALF   = ZW'(32768);
    localparam logic signed [ZW-1:0] Z_PI     = {2'b00, 1'b1, 31'b0};
    localparam logic [50:0] GAP_SQ = 51'(CLUSTER_GAP * CLUSTER_GAP);

    // register indexes
    localparam logic [2:0] REG_RANGE_LO = 3'd0;
    localparam logic [2:0] REG_RANGE_HI = 3'd1;
    localparam logic [2:0] REG_START    = 3'd2;
    localparam logic [2:0] REG_STEP     = 3'd3;
    localparam logic [2:0] REG_COS      = 3'd4;
    localparam logic [2:0] REG_SIN      = 3'd5;
    localparam logic [2:0] REG_OFS_X    = 3'd6;
    localparam logic [2:0] REG_OFS_Y    = 3'd7;

    typedef struct packed {
        logic [15:0] range_sample;
        logic        last_ray;
    } in_item_t;

    typedef struct packed {
        logic               landmark_valid;
        logic signed [23:0] centroid_x;
        logic signed [23:0] centroid_y;
        logic [23:0]        landmark_range;
        logic signed [15:0] landmark_bearing;
        logic [10:0]        point_count;
        logic               scan_end;
    } out_item_t;

    typedef struct packed {
        logic                 vld;
        logic                 vect;   // 1: vectoring, 0: rotation
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic signed [ZW-1:0] z;
    } cordic_bus_t;

    function automatic logic signed [ZW-1:0] atan_val(input logic [4:0] i);
        logic signed [ZW-1:0] v;
        case (i)
            5'd0:  v = ZW'(32'h20000000);
            5'd1:  v = ZW'(32'h12E4051E);
            5'd2:  v = ZW'(32'h09FB385B);
            5'd3:  v = ZW'(32'h051111D4);
            5'd4:  v = ZW'(32'h028B0D43);
            5'd5:  v = ZW'(32'h0145D7E1);
            5'd6:  v = ZW'(32'h00A2F61E);
            5'd7:  v = ZW'(32'h00517C55);
            5'd8:  v = ZW'(32'h0028BE53);
            5'd9:  v = ZW'(32'h00145F2F);
            5'd10: v = ZW'(32'h000A2F98);
            5'd11: v = ZW'(32'h000517CC);
            5'd12: v = ZW'(32'h00028BE6);
            5'd13: v = ZW'(32'h000145F3);
            5'd14: v = ZW'(32'h0000A2FA);
            5'd15: v = ZW'(32'h0000517D);
            5'd16: v = ZW'(32'h000028BE);
            5'd17: v = ZW'(32'h0000145F);
            5'd18: v = ZW'(32'h00000A30);
            5'd19: v = ZW'(32'h00000518);
            5'd20: v = ZW'(32'h0000028C);
            5'd21: v = ZW'(32'h00000146);
            5'd22: v = ZW'(32'h000000A3);
            5'd23: v = ZW'(32'h00000051);
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

// File: rtl/laser_scan_landmark_extractor_core.sv
// A valid ray holds the input through polar, transform, distance and decide states;
// a rejected ray only through finish. Each result passes the output state, a landmark
// first the dividers, setup, 16 CORDIC cells and root; a result waits on out_ready.
// One ray at a time: a new ray is accepted only once the previous one is done.
// Reset (rst_n, async low) clears scan state and loads register defaults.
// Depends on lsle_pkg, lsle_cordic_cell, lsle_divider, lsle_isqrt.
`timescale 1ns / 1ps

module laser_scan_landmark_extractor_core
    import lsle_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  in_item_t   in_item,
    output logic       out_valid,
    input  logic       out_ready,
    output out_item_t  out_item,
    input  logic       cfg_we,
    input  logic [2:0] cfg_index,
    input  logic [15:0] cfg_data
);

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_PGO    = 4'd1;
    localparam logic [3:0] S_POLAR  = 4'd2;
    localparam logic [3:0] S_MUL    = 4'd3;
    localparam logic [3:0] S_XFORM  = 4'd4;
    localparam logic [3:0] S_DIST   = 4'd5;
    localparam logic [3:0] S_DECIDE = 4'd6;
    localparam logic [3:0] S_FINISH = 4'd7;
    localparam logic [3:0] S_DIV    = 4'd8;
    localparam logic [3:0] S_DWAIT  = 4'd9;
    localparam logic [3:0] S_SQ     = 4'd10;
    localparam logic [3:0] S_BGO    = 4'd11;
    localparam logic [3:0] S_BEAR   = 4'd12;
    localparam logic [3:0] S_ROOT   = 4'd13;
    localparam logic [3:0] S_OUT    = 4'd14;

    // configuration
    logic [15:0]        lo_reg;
    logic [15:0]        hi_reg;
    logic [15:0]        start_reg;
    logic [14:0]        step_reg;
    logic signed [15:0] cos_reg;
    logic signed [15:0] sin_reg;
    logic signed [15:0] ofs_x_reg;
    logic signed [15:0] ofs_y_reg;

    logic [3:0]              state_reg;
    logic [3:0]              state_next;
    logic [RAY_W-1:0]        ray_cnt_reg;
    logic                    have_prev_reg;
    logic signed [23:0]      prev_x_reg;
    logic signed [23:0]      prev_y_reg;
    logic signed [SUM_W-1:0] sum_x_reg;
    logic signed [SUM_W-1:0] sum_y_reg;
    logic [CNT_W-1:0]        size_reg;
    logic                    pend_reg;
    logic                    end_reg;
    logic                    ok_reg;
    logic                    out_valid_reg;
    out_item_t               out_item_reg;
    out_item_t               res_reg;
    out_item_t               res_clr;

    logic [15:0]             r_reg;
    logic signed [15:0]      angle_reg;
    logic signed [19:0]      lx_reg;
    logic signed [19:0]      ly_reg;
    logic signed [35:0]      pcx_reg;
    logic signed [35:0]      psy_reg;
    logic signed [35:0]      psx_reg;
    logic signed [35:0]      pcy_reg;
    logic signed [23:0]      px_reg;
    logic signed [23:0]      py_reg;
    logic [49:0]             dxx_reg;
    logic [49:0]             dyy_reg;
    logic signed [SUM_W-1:0] emit_sx_reg;
    logic signed [SUM_W-1:0] emit_sy_reg;
    logic [CNT_W-1:0]        emit_n_reg;
    logic signed [23:0]      cx_reg;
    logic signed [23:0]      cy_reg;
    logic [47:0]             sqx_reg;
    logic [47:0]             sqy_reg;
    logic signed [15:0]      bear_reg;

    logic                    accept;
    logic                    sample_ok;
    logic                    ray_last;
    logic [RAY_W+14:0]       ang_prod;
    logic                    out_load;
    logic                    near;
    logic                    emit_now;
    logic                    go_emit;
    logic                    need_out;

    logic [32:0]             rk;
    logic signed [CW-1:0]    rk_s;
    logic signed [17:0]      a_ext;
    logic signed [17:0]      a_fold;
    logic                    fold;
    logic signed [CW-1:0]    bx;
    logic signed [CW-1:0]    by;
    logic signed [CW-1:0]    tx_r;
    logic signed [CW-1:0]    ty_r;
    logic signed [ZW-1:0]    tz_r;
    logic signed [36:0]      tsum_x;
    logic signed [36:0]      tsum_y;
    logic signed [23:0]      px_calc;
    logic signed [23:0]      py_calc;
    logic signed [24:0]      dx_d;
    logic signed [24:0]      dy_d;
    logic [RAD_W-1:0]        rad_in;
    logic signed [SUM_W-1:0] qx;
    logic signed [SUM_W-1:0] qy;
    logic                    dx_done;
    logic                    dy_done;
    logic                    sq_done;
    logic [23:0]             root;
    logic                    div_start;
    logic                    sq_start;

    cordic_bus_t             launch;
    cordic_bus_t             chain [0:CORDIC_STEPS];

    assign in_ready  = (state_reg == S_IDLE);
    assign accept    = in_valid && in_ready;
    assign sample_ok = !(in_item.range_sample < lo_reg || in_item.range_sample > hi_reg
                         || in_item.range_sample < 16'(MIN_RANGE));
    assign ray_last  = in_item.last_ray || (ray_cnt_reg == RAY_W'(MAX_RAYS - 1));
    assign ang_prod  = (RAY_W+15)'(ray_cnt_reg) * (RAY_W+15)'(step_reg);
    assign out_load  = (state_reg == S_OUT) && (!out_valid_reg || out_ready);

    // polar launch: fold the angle into +/- pi/2
    assign rk     = 33'(r_reg) * 33'(CORDIC_GAIN);
    assign rk_s   = CW'(rk);
    assign a_ext  = 18'(angle_reg);
    assign fold   = (angle_reg > 16'sd16384) || (angle_reg < -16'sd16384);
    assign a_fold = (angle_reg > 16'sd16384) ? a_ext - 18'sd32768 :
                    (angle_reg < -16'sd16384) ? a_ext + 18'sd32768 : a_ext;

    assign bx = CW'($signed({cx_reg, 8'b0}));
    assign by = CW'($signed({cy_reg, 8'b0}));

    always_comb
    begin
        launch = '0;
        if (state_reg == S_PGO)
        begin
            launch.vld = 1'b1;
            launch.x   = fold ? -rk_s : rk_s;
            launch.z   = {a_fold, 16'b0};
        end
        else if (state_reg == S_BGO)
        begin
            launch.vld  = 1'b1;
            launch.vect = 1'b1;
            launch.x    = cx_reg[23] ? -bx : bx;
            launch.y    = cx_reg[23] ? -by : by;
            launch.z    = cx_reg[23] ? Z_PI : '0;
        end
    end

    assign chain[0] = launch;

    genvar g;
    generate
        for (g = 0; g < CORDIC_STEPS; g++)
        begin : g_cell
            lsle_cordic_cell u_cell (
                .clk   (clk),
                .rst_n (rst_n),
                .din   (chain[g]),
                .step  (5'(g)),
                .dout  (chain[g+1])
            );
        end
    endgenerate

    assign tx_r = (chain[CORDIC_STEPS].x + CRD_HALF) >>> 16;
    assign ty_r = (chain[CORDIC_STEPS].y + CRD_HALF) >>> 16;
    assign tz_r = (chain[CORDIC_STEPS].z + Z_HALF) >>> 16;

    assign tsum_x  = 37'(pcx_reg) - 37'(psy_reg) + 37'sd8192;
    assign tsum_y  = 37'(psx_reg) + 37'(pcy_reg) + 37'sd8192;
    assign px_calc = 24'(tsum_x >>> 14) + 24'(ofs_x_reg);
    assign py_calc = 24'(tsum_y >>> 14) + 24'(ofs_y_reg);

    assign dx_d = 25'(px_reg) - 25'(prev_x_reg);
    assign dy_d = 25'(py_reg) - 25'(prev_y_reg);
    assign near = have_prev_reg && ((51'(dxx_reg) + 51'(dyy_reg)) < GAP_SQ);

    assign emit_now = end_reg && !pend_reg && (size_reg >= CNT_W'(MIN_POINTS));
    assign go_emit  = pend_reg || emit_now;
    assign need_out = pend_reg || end_reg;

    assign div_start = (state_reg == S_DIV);
    assign sq_start  = (state_reg == S_BGO);
    assign rad_in    = RAD_W'(sqx_reg) + RAD_W'(sqy_reg);

    always_comb
    begin
        res_clr          = '0;
        res_clr.scan_end = end_reg;
    end

    lsle_divider u_div_x (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (emit_sx_reg),
        .den   (emit_n_reg),
        .done  (dx_done),
        .quot  (qx)
    );

    lsle_divider u_div_y (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (emit_sy_reg),
        .den   (emit_n_reg),
        .done  (dy_done),
        .quot  (qy)
    );

    lsle_isqrt u_isqrt (
        .clk   (clk),
        .rst_n (rst_n),
        .start (sq_start),
        .rad   (rad_in),
        .done  (sq_done),
        .root  (root)
    );

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:   if (in_valid) state_next = sample_ok ? S_PGO : S_FINISH;
            S_PGO:    state_next = S_POLAR;
            S_POLAR:  if (chain[CORDIC_STEPS].vld) state_next = S_MUL;
            S_MUL:    state_next = S_XFORM;
            S_XFORM:  state_next = S_DIST;
            S_DIST:   state_next = S_DECIDE;
            S_DECIDE: state_next = S_FINISH;
            S_FINISH: state_next = go_emit ? S_DIV : (need_out ? S_OUT : S_IDLE);
            S_DIV:    state_next = S_DWAIT;
            S_DWAIT:  if (dx_done && dy_done) state_next = S_SQ;
            S_SQ:     state_next = S_BGO;
            S_BGO:    state_next = S_BEAR;
            S_BEAR:   if (chain[CORDIC_STEPS].vld) state_next = S_ROOT;
            S_ROOT:   if (sq_done) state_next = S_OUT;
            S_OUT:    if (out_load) state_next = S_IDLE;
            default:  state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lo_reg        <= 16'd0;
            hi_reg        <= 16'hFFFF;
            start_reg     <= 16'h8000;
            step_reg      <= 15'd64;
            cos_reg       <= 16'sd16384;
            sin_reg       <= '0;
            ofs_x_reg     <= '0;
            ofs_y_reg     <= '0;
            state_reg     <= S_IDLE;
            ray_cnt_reg   <= '0;
            have_prev_reg <= 1'b0;
            sum_x_reg     <= '0;
            sum_y_reg     <= '0;
            size_reg      <= '0;
            pend_reg      <= 1'b0;
            end_reg       <= 1'b0;
            ok_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_RANGE_LO: lo_reg    <= cfg_data;
                    REG_RANGE_HI: hi_reg    <= cfg_data;
                    REG_START:    start_reg <= cfg_data;
                    REG_STEP:     step_reg  <= cfg_data[14:0];
                    REG_COS:      cos_reg   <= cfg_data;
                    REG_SIN:      sin_reg   <= cfg_data;
                    REG_OFS_X:    ofs_x_reg <= cfg_data;
                    REG_OFS_Y:    ofs_y_reg <= cfg_data;
                    default:      lo_reg    <= lo_reg;
                endcase
            end
            if (accept)
            begin
                end_reg  <= ray_last;
                ok_reg   <= sample_ok;
                pend_reg <= 1'b0;
            end
            if (state_reg == S_DECIDE)
            begin
                if (!near)
                begin
                    pend_reg  <= (size_reg >= CNT_W'(MIN_POINTS));
                    sum_x_reg <= SUM_W'(px_reg);
                    sum_y_reg <= SUM_W'(py_reg);
                    size_reg  <= CNT_W'(1);
                end
                else
                begin
                    sum_x_reg <= sum_x_reg + SUM_W'(px_reg);
                    sum_y_reg <= sum_y_reg + SUM_W'(py_reg);
                    size_reg  <= size_reg + 1'b1;
                end
                have_prev_reg <= 1'b1;
            end
            if (state_reg == S_FINISH)
            begin
                if (end_reg)
                begin
                    ray_cnt_reg   <= '0;
                    have_prev_reg <= 1'b0;
                    sum_x_reg     <= '0;
                    sum_y_reg     <= '0;
                    size_reg      <= '0;
                end
                else
                begin
                    ray_cnt_reg <= ray_cnt_reg + 1'b1;
                end
            end
            if (out_valid_reg && out_ready)
                out_valid_reg <= 1'b0;
            if (out_load)
                out_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            r_reg     <= in_item.range_sample;
            angle_reg <= start_reg + ang_prod[15:0];
        end
        if (state_reg == S_POLAR)
        begin
            lx_reg <= tx_r[19:0];
            ly_reg <= ty_r[19:0];
        end
        if (state_reg == S_MUL)
        begin
            pcx_reg <= 36'(cos_reg) * 36'(lx_reg);
            psy_reg <= 36'(sin_reg) * 36'(ly_reg);
            psx_reg <= 36'(sin_reg) * 36'(lx_reg);
            pcy_reg <= 36'(cos_reg) * 36'(ly_reg);
        end
        if (state_reg == S_XFORM)
        begin
            px_reg <= px_calc;
            py_reg <= py_calc;
        end
        if (state_reg == S_DIST)
        begin
            dxx_reg <= 50'(dx_d) * 50'(dx_d);
            dyy_reg <= 50'(dy_d) * 50'(dy_d);
        end
        if (state_reg == S_DECIDE)
        begin
            // closing cluster is captured before it is cleared
            if (!near)
            begin
                emit_sx_reg <= sum_x_reg;
                emit_sy_reg <= sum_y_reg;
                emit_n_reg  <= size_reg;
            end
            prev_x_reg <= px_reg;
            prev_y_reg <= py_reg;
        end
        if (state_reg == S_FINISH)
        begin
            if (emit_now)
            begin
                emit_sx_reg <= sum_x_reg;
                emit_sy_reg <= sum_y_reg;
                emit_n_reg  <= size_reg;
            end
            res_reg <= res_clr;
        end
        if (state_reg == S_DWAIT)
        begin
            cx_reg <= qx[23:0];
            cy_reg <= qy[23:0];
        end
        if (state_reg == S_SQ)
        begin
            sqx_reg <= 48'(cx_reg) * 48'(cx_reg);
            sqy_reg <= 48'(cy_reg) * 48'(cy_reg);
        end
        if (state_reg == S_BEAR)
            bear_reg <= (cx_reg == '0 && cy_reg == '0) ? '0 : tz_r[15:0];
        if (state_reg == S_ROOT)
        begin
            res_reg <= {1'b1, cx_reg, cy_reg, root, bear_reg,
                        (32'(emit_n_reg) > 32'd2047) ? 11'd2047 : 11'(emit_n_reg),
                        res_reg.scan_end};
        end
        if (out_load)
            out_item_reg <= res_reg;
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

    // a rejected sample never launches the polar conversion
    a_reject_path: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_PGO) |-> ok_reg)
        else $error("polar launch for rejected sample");

    // a blocked result holds the sequencer
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_OUT && out_valid_reg && !out_ready) |=> (state_reg == S_OUT))
        else $error("result dropped while output busy");

    // a remembered point always belongs to an open cluster
    a_prev_size: assert property (@(posedge clk) disable iff (!rst_n)
        have_prev_reg |-> (size_reg != '0))
        else $error("cluster empty with previous point");

    // end of scan returns the ray count to zero
    a_scan_wrap: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FINISH && end_reg) |=> (ray_cnt_reg == '0 && !have_prev_reg))
        else $error("scan state not cleared at end of scan");

endmodule

// File: rtl/lsle_cordic_cell.sv
// One registered CORDIC micro-rotation; cells are chained, one per step.
// Depends on lsle_pkg (bus type, angle table).
`timescale 1ns / 1ps

module lsle_cordic_cell
    import lsle_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  cordic_bus_t din,
    input  logic [4:0]  step,
    output cordic_bus_t dout
);

    logic                 vld_reg;
    cordic_bus_t          data_reg;
    cordic_bus_t          data_next;
    logic                 up;
    logic signed [CW-1:0] dx;
    logic signed [CW-1:0] dy;

    // rotation steers on z, vectoring drives y toward zero
    assign up = din.vect ? din.y[CW-1] : !din.z[ZW-1];
    assign dx = din.y >>> step;
    assign dy = din.x >>> step;

    always_comb
    begin
        data_next = din;
        if (up)
        begin
            data_next.x = din.x - dx;
            data_next.y = din.y + dy;
            data_next.z = din.z - atan_val(step);
        end
        else
        begin
            data_next.x = din.x + dx;
            data_next.y = din.y - dy;
            data_next.z = din.z + atan_val(step);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= 1'b0;
        else
            vld_reg <= din.vld;
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    always_comb
    begin
        dout     = data_reg;
        dout.vld = vld_reg;
    end

endmodule

// File: rtl/lsle_divider.sv
// Restoring divider, one quotient bit per cycle, round half away from zero.
// Depends on lsle_pkg (widths).
`timescale 1ns / 1ps

module lsle_divider
    import lsle_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    input  logic signed [SUM_W-1:0] num,
    input  logic [CNT_W-1:0]        den,
    output logic                    done,
    output logic signed [SUM_W-1:0] quot
);

    localparam int DVD_W = SUM_W + 1;
    localparam int CTR_W = $clog2(DVD_W + 1);

    logic [DVD_W-1:0] dvd_reg;
    logic [CNT_W-1:0] rem_reg;
    logic [CTR_W-1:0] cnt_reg;
    logic             busy_reg;
    logic             done_reg;
    logic             neg_reg;
    logic [SUM_W-1:0] mag;
    logic [CNT_W:0]   trial;
    logic             fits;

    assign mag   = num[SUM_W-1] ? SUM_W'(-num) : SUM_W'(num);
    assign trial = {rem_reg, dvd_reg[DVD_W-1]};
    assign fits  = trial >= {1'b0, den};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= CTR_W'(DVD_W);
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == CTR_W'(1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            // bias by half the divisor so truncation rounds to nearest
            dvd_reg <= DVD_W'(mag) + DVD_W'(den >> 1);
            rem_reg <= '0;
            neg_reg <= num[SUM_W-1];
        end
        else if (busy_reg)
        begin
            rem_reg <= fits ? CNT_W'(trial - {1'b0, den}) : trial[CNT_W-1:0];
            dvd_reg <= {dvd_reg[DVD_W-2:0], fits};
        end
    end

    assign done = done_reg;
    assign quot = neg_reg ? -$signed(dvd_reg[SUM_W-1:0]) : $signed(dvd_reg[SUM_W-1:0]);

endmodule

// File: rtl/lsle_isqrt.sv
// Digit-by-digit integer square root, two radicand bits per cycle, rounded.
// Depends on lsle_pkg (widths).
`timescale 1ns / 1ps

module lsle_isqrt
    import lsle_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [RAD_W-1:0] rad,
    output logic             done,
    output logic [23:0]      root
);

    logic [RAD_W-1:0] v_reg;
    logic [RAD_W-1:0] r_reg;
    logic [RAD_W-1:0] bit_reg;
    logic             busy_reg;
    logic             done_reg;
    logic [RAD_W-1:0] trial;

    assign trial = r_reg + bit_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
        end
        else if (busy_reg && bit_reg == '0)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            v_reg   <= rad;
            r_reg   <= '0;
            bit_reg <= RAD_W'(1) << (RAD_W - 2);
        end
        else if (busy_reg && bit_reg != '0)
        begin
            if (v_reg >= trial)
            begin
                v_reg <= v_reg - trial;
                r_reg <= (r_reg >> 1) + bit_reg;
            end
            else
            begin
                r_reg <= r_reg >> 1;
            end
            bit_reg <= bit_reg >> 2;
        end
    end

    // remainder above the root means the true root is past the half point
    assign done = done_reg;
    assign root = (v_reg > r_reg) ? 24'(r_reg + 1'b1) : 24'(r_reg);

endmodule
